// ===== rtl/service_ratio_process_scheduler_assert.svh =====
// Assertion macros for the service ratio scheduler
`ifndef SERVICE_RATIO_PROCESS_SCHEDULER_ASSERT_SVH
`define SERVICE_RATIO_PROCESS_SCHEDULER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SRPS_CHECK(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define SRPS_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/srps_pkg.sv =====
// Shared types, constants and time arithmetic for the service ratio scheduler
package srps_pkg;

   localparam int SLOTS  = 32;
   localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int FILL_W = $clog2(SLOTS + 1);
   localparam int CNT_W  = 6;

   localparam logic [29:0] NS_PER_SEC     = 30'd1000000000;
   localparam logic [31:0] NS_TWO_SEC     = 32'd2000000000;
   localparam logic [61:0] SEC_SPAN       = 62'd4294967296000000000;
   localparam logic [29:0] SLICE_RESET    = 30'd50000000;
   localparam logic [29:0] OVERHEAD_RESET = 30'd500000;

   typedef enum logic [1:0] {
      FUNC_ADD      = 2'd0,
      FUNC_DISPATCH = 2'd1,
      FUNC_REPORT   = 2'd2,
      FUNC_ADVANCE  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STAT_OK         = 2'd0,
      STAT_FULL       = 2'd1,
      STAT_UNKNOWN    = 2'd2,
      STAT_NONE_READY = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      OUT_READY      = 2'd0,
      OUT_BLOCKED    = 2'd1,
      OUT_TERMINATED = 2'd2
   } outcome_type;

   typedef enum logic [1:0] {
      ST_EMPTY   = 2'd0,
      ST_READY   = 2'd1,
      ST_RUNNING = 2'd2,
      ST_BLOCKED = 2'd3
   } slot_st_type;

   typedef enum logic {
      CSR_SLICE    = 1'b0,
      CSR_OVERHEAD = 1'b1
   } csr_idx_type;

   typedef struct packed {
      logic [31:0] sec;
      logic [29:0] ns;
   } time_type;

   // one table entry; service time is kept as flat nanoseconds modulo the seconds span
   typedef struct packed {
      logic [15:0] id;
      slot_st_type st;
      time_type    start;
      logic [61:0] svc;
      time_type    wake;
   } entry_type;

   typedef struct packed {
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
   } tbl_ctl_type;

   // add up to about two seconds of nanoseconds with full carry, seconds wrapping
   function automatic time_type time_add(time_type t, logic [30:0] v);
      logic [31:0] sum;
      time_type    r;
      sum = {2'b00, t.ns} + {1'b0, v};
      if (sum >= NS_TWO_SEC) begin
         r.sec = t.sec + 32'd2;
         r.ns  = 30'(sum - NS_TWO_SEC);
      end else if (sum >= {2'b00, NS_PER_SEC}) begin
         r.sec = t.sec + 32'd1;
         r.ns  = 30'(sum - {2'b00, NS_PER_SEC});
      end else begin
         r.sec = t.sec;
         r.ns  = sum[29:0];
      end
      return r;
   endfunction

   // add nanoseconds to a flat service time modulo the seconds span
   function automatic logic [61:0] svc_add(logic [61:0] s, logic [30:0] v);
      logic [62:0] sum;
      sum = {1'b0, s} + {32'b0, v};
      if (sum >= {1'b0, SEC_SPAN}) begin
         return 62'(sum - {1'b0, SEC_SPAN});
      end
      return sum[61:0];
   endfunction

endpackage

// ===== rtl/srps_if.sv =====
// Handshake channel interfaces for request and response words
interface srps_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         func;
   logic [15:0]        client_id;
   logic signed [30:0] run_ns;
   logic [7:0]         wait_sec;
   logic [29:0]        wait_nanos;
   logic [29:0]        advance_ns;

   modport source (
      output valid, func, client_id, run_ns, wait_sec, wait_nanos, advance_ns,
      input  ready
   );
   modport sink (
      input  valid, func, client_id, run_ns, wait_sec, wait_nanos, advance_ns,
      output ready
   );
endinterface

interface srps_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [15:0] picked_id;
   logic [5:0]  woken_count;
   logic [1:0]  outcome;
   logic [31:0] now_sec;
   logic [29:0] now_ns;

   modport source (
      output valid, status, picked_id, woken_count, outcome, now_sec, now_ns,
      input  ready
   );
   modport sink (
      input  valid, status, picked_id, woken_count, outcome, now_sec, now_ns,
      output ready
   );
endinterface

// ===== rtl/service_ratio_process_scheduler.sv =====
// Top level: sequencer, clock and registers of the service ratio scheduler
//
//  channel   direction  contents
//  req_chan  in         func, client_id, run_ns, wait_sec, wait_nanos, advance_ns
//  rsp_chan  out        status, picked_id, woken_count, outcome, now_sec, now_ns
//  csr_*     in         write enable, register index, 30-bit write data
//
// A run report walks the table once; dispatch walks it twice through its single read
// port, and each ratio compare shares one 31x31 multiplier over eight partial products.
// Reset is synchronous; the table needs no clearing pass, a fill count marks live slots.
// One word is worked at a time; the next is taken while a result waits on rsp_chan.
`include "service_ratio_process_scheduler_assert.svh"

module service_ratio_process_scheduler (
   input  logic        clock,
   input  logic        reset,
   srps_req_if.sink    req_chan,
   srps_rsp_if.source  rsp_chan,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [29:0] csr_wdata
);
   import srps_pkg::*;

   typedef enum logic [14:0] {
      S_IDLE     = 15'h0001,
      S_DECODE   = 15'h0002,
      S_WK_RD    = 15'h0004,
      S_WK_PROC  = 15'h0008,
      S_PK_RD    = 15'h0010,
      S_PK_PROC  = 15'h0020,
      S_PK_TFLAT = 15'h0040,
      S_PK_CMP   = 15'h0080,
      S_PK_WAIT  = 15'h0100,
      S_PK_END   = 15'h0200,
      S_FIN_WR   = 15'h0400,
      S_RP_RD    = 15'h0800,
      S_RP_PROC  = 15'h1000,
      S_RP_END   = 15'h2000,
      S_DONE     = 15'h4000
   } fsm_type;

   typedef struct packed {
      func_type    func;
      logic [15:0] wid;
      logic [30:0] run;
      logic [7:0]  wait_sec;
      logic [29:0] wait_nanos;
      logic [29:0] adv;
   } item_type;

   fsm_type           state_ff, state_in;
   item_type          item_ff, item_in;
   time_type          clk_ff, clk_in;
   time_type          snap_ff, snap_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              found_ff, found_in;
   logic [IDX_W-1:0]  best_ff, best_in;
   logic [15:0]       best_id_ff, best_id_in;
   logic [61:0]       bs_ff, bs_in, bt_ff, bt_in;
   logic [31:0]       dsec_ff, dsec_in;
   logic [29:0]       dns_ff, dns_in;
   logic [61:0]       s_ff, s_in, t_ff, t_in;
   status_type        res_status_ff, res_status_in;
   logic [15:0]       res_picked_ff, res_picked_in;
   outcome_type       res_outcome_ff, res_outcome_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [15:0]       rsp_picked_ff, rsp_picked_in;
   logic [CNT_W-1:0]  rsp_woken_ff, rsp_woken_in;
   outcome_type       rsp_outcome_ff, rsp_outcome_in;
   time_type          rsp_now_ff, rsp_now_in;
   logic [29:0]       slice_ff, slice_in, ovh_ff, ovh_in;

   tbl_ctl_type       tbl_ctl;
   entry_type         tbl_wdata;
   entry_type         rd;
   logic              ratio_start, ratio_done, ratio_less;

   logic              ent_ok, last;
   logic [30:0]       mag;
   slot_st_type       rpt_st;
   outcome_type       rpt_oc;
   time_type          wake_base, wake_t;
   logic [30:0]       dns_w;
   logic [61:0]       tprod, s_eff, t_eff;

   srps_table u_table (
      .clock   (clock),
      .ctl     (tbl_ctl),
      .wr_data (tbl_wdata),
      .rd_data (rd)
   );

   srps_ratio u_ratio (
      .clock (clock),
      .reset (reset),
      .start (ratio_start),
      .s     (s_eff),
      .t     (t_eff),
      .bs    (bs_ff),
      .bt    (bt_ff),
      .done  (ratio_done),
      .less  (ratio_less)
   );

   // decode the run report and the walk position
   always_comb begin
      ent_ok = (FILL_W'(idx_ff) < fill_ff);
      last   = (idx_ff == IDX_W'(SLOTS - 1));
      mag    = item_ff.run[30] ? (~item_ff.run + 31'd1) : item_ff.run;
      if (item_ff.run[30]) begin
         rpt_st = ST_EMPTY;
         rpt_oc = OUT_TERMINATED;
      end else if (mag < {1'b0, slice_ff}) begin
         rpt_st = ST_BLOCKED;
         rpt_oc = OUT_BLOCKED;
      end else begin
         rpt_st = ST_READY;
         rpt_oc = OUT_READY;
      end
      wake_base.sec = clk_ff.sec + {24'b0, item_ff.wait_sec};
      wake_base.ns  = clk_ff.ns;
      wake_t        = time_add(wake_base, {1'b0, item_ff.wait_nanos});
      dns_w         = {1'b0, clk_ff.ns} - {1'b0, rd.start.ns};
      tprod         = {30'b0, dsec_ff} * {32'b0, NS_PER_SEC};
      s_eff         = (t_ff == 62'd0) ? 62'd0 : s_ff;
      t_eff         = (t_ff == 62'd0) ? 62'd1 : t_ff;
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      item_in        = item_ff;
      clk_in         = clk_ff;
      snap_in        = snap_ff;
      fill_in        = fill_ff;
      idx_in         = idx_ff;
      cnt_in         = cnt_ff;
      found_in       = found_ff;
      best_in        = best_ff;
      best_id_in     = best_id_ff;
      bs_in          = bs_ff;
      bt_in          = bt_ff;
      dsec_in        = dsec_ff;
      dns_in         = dns_ff;
      s_in           = s_ff;
      t_in           = t_ff;
      res_status_in  = res_status_ff;
      res_picked_in  = res_picked_ff;
      res_outcome_in = res_outcome_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_picked_in  = rsp_picked_ff;
      rsp_woken_in   = rsp_woken_ff;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_now_in     = rsp_now_ff;
      slice_in       = slice_ff;
      ovh_in         = ovh_ff;
      tbl_ctl        = '0;
      tbl_wdata      = rd;
      ratio_start    = 1'b0;

      // take register writes
      if (csr_we) begin
         if (csr_index == CSR_SLICE) begin
            slice_in = csr_wdata;
         end else begin
            ovh_in = csr_wdata;
         end
      end

      // drop the result word once taken
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               item_in.func       = func_type'(req_chan.func);
               item_in.wid        = req_chan.client_id;
               item_in.run        = req_chan.run_ns;
               item_in.wait_sec   = req_chan.wait_sec;
               item_in.wait_nanos = req_chan.wait_nanos;
               item_in.adv        = req_chan.advance_ns;
               state_in           = S_DECODE;
            end
         end
         S_DECODE: begin
            res_status_in  = STAT_OK;
            res_picked_in  = 16'd0;
            res_outcome_in = OUT_READY;
            cnt_in         = '0;
            found_in       = 1'b0;
            idx_in         = '0;
            case (item_ff.func)
               FUNC_ADD: begin
                  if (item_ff.wid == 16'd0) begin
                     res_status_in = STAT_UNKNOWN;
                  end else if (fill_ff == FILL_W'(SLOTS)) begin
                     res_status_in = STAT_FULL;
                  end else begin
                     tbl_ctl.wr_en   = 1'b1;
                     tbl_ctl.wr_addr = fill_ff[IDX_W-1:0];
                     tbl_wdata.id    = item_ff.wid;
                     tbl_wdata.st    = ST_READY;
                     tbl_wdata.start = clk_ff;
                     tbl_wdata.svc   = '0;
                     tbl_wdata.wake  = '0;
                     fill_in         = fill_ff + FILL_W'(1);
                     clk_in          = time_add(clk_ff, {1'b0, ovh_ff});
                  end
                  state_in = S_DONE;
               end
               FUNC_DISPATCH: begin
                  snap_in  = clk_ff;
                  state_in = S_WK_RD;
               end
               FUNC_REPORT: begin
                  state_in = S_RP_RD;
               end
               FUNC_ADVANCE: begin
                  clk_in   = time_add(clk_ff, {1'b0, item_ff.adv});
                  state_in = S_DONE;
               end
               default: state_in = S_DONE;
            endcase
         end

         // wake pass: blocked entries due by the clock at dispatch start
         S_WK_RD: begin
            tbl_ctl.rd_en   = 1'b1;
            tbl_ctl.rd_addr = idx_ff;
            state_in        = S_WK_PROC;
         end
         S_WK_PROC: begin
            if (ent_ok && rd.st == ST_BLOCKED &&
                {rd.wake.sec, rd.wake.ns} <= {snap_ff.sec, snap_ff.ns}) begin
               tbl_ctl.wr_en   = 1'b1;
               tbl_ctl.wr_addr = idx_ff;
               tbl_wdata.st    = ST_READY;
               tbl_wdata.wake  = '0;
               cnt_in          = (cnt_ff == {CNT_W{1'b1}}) ? cnt_ff : cnt_ff + CNT_W'(1);
               clk_in          = time_add(clk_ff, {1'b0, ovh_ff});
            end
            if (last) begin
               idx_in   = '0;
               state_in = S_PK_RD;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = S_WK_RD;
            end
         end

         // pick pass: lowest service ratio among ready entries
         S_PK_RD: begin
            tbl_ctl.rd_en   = 1'b1;
            tbl_ctl.rd_addr = idx_ff;
            state_in        = S_PK_PROC;
         end
         S_PK_PROC: begin
            if (ent_ok && rd.st == ST_READY) begin
               dns_in   = dns_w[30] ? 30'(dns_w + {1'b0, NS_PER_SEC}) : dns_w[29:0];
               dsec_in  = clk_ff.sec - rd.start.sec - {31'b0, dns_w[30]};
               s_in     = rd.svc;
               state_in = S_PK_TFLAT;
            end else if (last) begin
               state_in = S_PK_END;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = S_PK_RD;
            end
         end
         S_PK_TFLAT: begin
            t_in     = tprod + {32'b0, dns_ff};
            state_in = S_PK_CMP;
         end
         S_PK_CMP: begin
            if (!found_ff) begin
               found_in   = 1'b1;
               best_in    = idx_ff;
               best_id_in = rd.id;
               bs_in      = s_eff;
               bt_in      = t_eff;
               if (last) begin
                  state_in = S_PK_END;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = S_PK_RD;
               end
            end else begin
               ratio_start = 1'b1;
               state_in    = S_PK_WAIT;
            end
         end
         S_PK_WAIT: begin
            if (ratio_done) begin
               if (ratio_less) begin
                  best_in    = idx_ff;
                  best_id_in = rd.id;
                  bs_in      = s_eff;
                  bt_in      = t_eff;
               end
               if (last) begin
                  state_in = S_PK_END;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = S_PK_RD;
               end
            end
         end
         S_PK_END: begin
            clk_in = time_add(clk_ff, {1'b0, ovh_ff});
            if (found_ff) begin
               res_picked_in   = best_id_ff;
               tbl_ctl.rd_en   = 1'b1;
               tbl_ctl.rd_addr = best_ff;
               state_in        = S_FIN_WR;
            end else begin
               res_status_in = STAT_NONE_READY;
               state_in      = S_DONE;
            end
         end
         S_FIN_WR: begin
            tbl_ctl.wr_en   = 1'b1;
            tbl_ctl.wr_addr = best_ff;
            tbl_wdata.st    = ST_RUNNING;
            state_in        = S_DONE;
         end

         // report pass: update every live entry with the id
         S_RP_RD: begin
            tbl_ctl.rd_en   = 1'b1;
            tbl_ctl.rd_addr = idx_ff;
            state_in        = S_RP_PROC;
         end
         S_RP_PROC: begin
            if (ent_ok && rd.id == item_ff.wid && rd.st != ST_EMPTY) begin
               found_in        = 1'b1;
               tbl_ctl.wr_en   = 1'b1;
               tbl_ctl.wr_addr = idx_ff;
               tbl_wdata.st    = rpt_st;
               tbl_wdata.svc   = svc_add(rd.svc, mag);
               if (rpt_st == ST_BLOCKED) begin
                  tbl_wdata.wake = wake_t;
               end
            end
            if (last) begin
               state_in = S_RP_END;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = S_RP_RD;
            end
         end
         S_RP_END: begin
            if (found_ff) begin
               clk_in         = time_add(clk_ff, mag);
               res_outcome_in = rpt_oc;
            end else begin
               res_status_in = STAT_UNKNOWN;
            end
            state_in = S_DONE;
         end

         // hand the result word to the output register
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = res_status_ff;
               rsp_picked_in  = res_picked_ff;
               rsp_woken_in   = cnt_ff;
               rsp_outcome_in = res_outcome_ff;
               rsp_now_in     = clk_ff;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         clk_ff       <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         slice_ff     <= SLICE_RESET;
         ovh_ff       <= OVERHEAD_RESET;
      end else begin
         state_ff     <= state_in;
         clk_ff       <= clk_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         slice_ff     <= slice_in;
         ovh_ff       <= ovh_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff        <= item_in;
      snap_ff        <= snap_in;
      idx_ff         <= idx_in;
      cnt_ff         <= cnt_in;
      found_ff       <= found_in;
      best_ff        <= best_in;
      best_id_ff     <= best_id_in;
      bs_ff          <= bs_in;
      bt_ff          <= bt_in;
      dsec_ff        <= dsec_in;
      dns_ff         <= dns_in;
      s_ff           <= s_in;
      t_ff           <= t_in;
      res_status_ff  <= res_status_in;
      res_picked_ff  <= res_picked_in;
      res_outcome_ff <= res_outcome_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_picked_ff  <= rsp_picked_in;
      rsp_woken_ff   <= rsp_woken_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_now_ff     <= rsp_now_in;
   end

   assign req_chan.ready       = (state_ff == S_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.picked_id   = rsp_picked_ff;
   assign rsp_chan.woken_count = rsp_woken_ff;
   assign rsp_chan.outcome     = rsp_outcome_ff;
   assign rsp_chan.now_sec     = rsp_now_ff.sec;
   assign rsp_chan.now_ns      = rsp_now_ff.ns;

   `SRPS_CHECK(a_fill_bound, 1'b1, fill_ff <= FILL_W'(SLOTS), "fill count beyond table size")
   `SRPS_CHECK(a_clock_norm, 1'b1, clk_ff.ns < NS_PER_SEC, "clock nanoseconds not normalised")
   `SRPS_CHECK(a_port_clash, tbl_ctl.rd_en && tbl_ctl.wr_en, tbl_ctl.rd_addr != tbl_ctl.wr_addr, "table read and write hit one entry")
   `SRPS_NEXT(a_cmp_wait, ratio_start, state_ff == S_PK_WAIT, "compare started outside the pick walk")
   `SRPS_CHECK(a_done_wait, ratio_done, state_ff == S_PK_WAIT, "compare finished with no one waiting")

endmodule

// ===== rtl/srps_table.sv =====
// Worker table memory: one write port, one registered read port
module srps_table (
   input  logic                  clock,
   input  srps_pkg::tbl_ctl_type ctl,
   input  srps_pkg::entry_type   wr_data,
   output srps_pkg::entry_type   rd_data
);
   import srps_pkg::*;

   entry_type mem_ff [SLOTS];
   entry_type rd_data_ff;

   // write one entry
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[ctl.wr_addr] <= wr_data;
      end
   end

   // read one entry, hold the word until the next read
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem_ff[ctl.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/srps_ratio.sv =====
// Ratio compare unit: sign of s*bt - bs*t from eight 31x31 partial products
module srps_ratio (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [61:0] s,
   input  logic [61:0] t,
   input  logic [61:0] bs,
   input  logic [61:0] bt,
   output logic        done,
   output logic        less
);
   import srps_pkg::*;

   localparam int ACC_W = 126;

   logic [61:0]      s_ff, t_ff, bs_ff, bt_ff;
   logic [61:0]      s_in, t_in, bs_in, bt_in;
   logic [61:0]      pp_ff, pp_in;
   logic [2:0]       pstep_ff, pstep_in;
   logic             pv_ff, pv_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [3:0]       cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [30:0]      mul_x, mul_y;
   logic [ACC_W-1:0] ext;

   // pick the operand halves for this step
   always_comb begin
      case (cnt_ff[2:1])
         2'd0:    mul_x = s_ff[30:0];
         2'd1:    mul_x = s_ff[61:31];
         2'd2:    mul_x = bs_ff[30:0];
         default: mul_x = bs_ff[61:31];
      endcase
      if (cnt_ff[2]) begin
         mul_y = cnt_ff[0] ? t_ff[61:31] : t_ff[30:0];
      end else begin
         mul_y = cnt_ff[0] ? bt_ff[61:31] : bt_ff[30:0];
      end
   end

   // align the registered partial product
   always_comb begin
      case (pstep_ff[1:0])
         2'd0:       ext = {64'b0, pp_ff};
         2'd1, 2'd2: ext = {33'b0, pp_ff, 31'b0};
         default:    ext = {2'b0, pp_ff, 62'b0};
      endcase
   end

   // step the multiplier and accumulate
   always_comb begin
      s_in     = s_ff;
      t_in     = t_ff;
      bs_in    = bs_ff;
      bt_in    = bt_ff;
      pp_in    = pp_ff;
      pstep_in = pstep_ff;
      pv_in    = 1'b0;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      run_in   = run_ff;
      done_in  = 1'b0;
      if (start) begin
         s_in   = s;
         t_in   = t;
         bs_in  = bs;
         bt_in  = bt;
         acc_in = '0;
         cnt_in = 4'd0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!cnt_ff[3]) begin
            pp_in    = {31'b0, mul_x} * {31'b0, mul_y};
            pstep_in = cnt_ff[2:0];
            pv_in    = 1'b1;
         end
         if (pv_ff) begin
            acc_in = pstep_ff[2] ? acc_ff - ext : acc_ff + ext;
         end
         if (cnt_ff[3]) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
         cnt_in = cnt_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         pv_ff   <= 1'b0;
         cnt_ff  <= 4'd0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         pv_ff   <= pv_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff     <= s_in;
      t_ff     <= t_in;
      bs_ff    <= bs_in;
      bt_ff    <= bt_in;
      pp_ff    <= pp_in;
      pstep_ff <= pstep_in;
      acc_ff   <= acc_in;
   end

   assign done = done_ff;
   assign less = acc_ff[ACC_W-1];

endmodule
